@@ hdl/plli_pkg.sv @@
// Package with shared types, constants and state codes for the PWL interpolator.
package plli_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        REQ_LOAD    = 2'd0,
        REQ_FORWARD = 2'd1,
        REQ_REVERSE = 2'd2,
        REQ_CLEAR   = 2'd3
    } req_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] key_value;
        logic signed [31:0] out_value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               table_empty;
        logic               table_full;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_INS_READ,
        ST_INS_STEP,
        ST_INS_DONE,
        ST_Q_READ,
        ST_Q_STEP,
        ST_Q_LO,
        ST_Q_HI,
        ST_MUL,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic       capture;
        logic       q_start;
        logic       ins_read;
        logic       ins_step;
        logic       ins_done;
        logic       q_read;
        logic       q_step;
        logic       q_lo;
        logic       q_hi;
        logic       mul;
        logic       div_step;
        logic       fin;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        req_t       req;
        logic       count_zero;
        logic       count_full;
        logic       ins_stop;
        logic       q_below_lo;
        logic       q_above_hi;
        logic       q_found;
        logic       q_last;
        logic       div_skip;
        logic       div_last;
    } status_t;

endpackage

@@ hdl/piecewise_linear_lut_interpolator_core.sv @@
// Top level of the piecewise-linear lookup table interpolator.
// One transaction in gives exactly one transaction out. A load walks the two sorted copies
// from the top, with a read state and a step state per shifted entry. A query clamps
// against the end entries, scans for the first bracketing pair, then forms the exact 64-bit
// product in one 32x32 multiply and divides it by a restoring divider at one bit per cycle
// (64 steps after loading the dividend). A new request can be taken while the previous
// result still waits; its own result is then held back until the waiting one has been
// handed over. The contents of entries that were never loaded are never used.
module piecewise_linear_lut_interpolator_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  plli_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output plli_pkg::out_item_t out_data
);

    plli_pkg::cmd_t    cmd;
    plli_pkg::status_t status;

    plli_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    plli_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_data),
        .cmd      (cmd),
        .status   (status),
        .out_item (out_data)
    );

endmodule

@@ hdl/plli_ctrl.sv @@
// Controller state machine for the PWL interpolator.
module plli_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  plli_pkg::status_t status,
    output plli_pkg::cmd_t    cmd
);

    plli_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= plli_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == plli_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            plli_pkg::ST_IDLE:
                if (in_valid) state_next = plli_pkg::ST_DISPATCH;
            plli_pkg::ST_DISPATCH:
                priority if (status.req == plli_pkg::REQ_CLEAR) state_next = plli_pkg::ST_FIN;
                else if (status.req == plli_pkg::REQ_LOAD)
                    state_next = status.count_full ? plli_pkg::ST_FIN : plli_pkg::ST_INS_READ;
                else
                    state_next = status.count_zero ? plli_pkg::ST_FIN : plli_pkg::ST_Q_LO;
            plli_pkg::ST_INS_READ:
                state_next = status.ins_stop ? plli_pkg::ST_INS_DONE : plli_pkg::ST_INS_STEP;
            plli_pkg::ST_INS_STEP:
                state_next = plli_pkg::ST_INS_READ;
            plli_pkg::ST_INS_DONE:
                state_next = plli_pkg::ST_FIN;
            plli_pkg::ST_Q_LO:
                state_next = status.q_below_lo ? plli_pkg::ST_FIN : plli_pkg::ST_Q_HI;
            plli_pkg::ST_Q_HI:
                state_next = status.q_above_hi ? plli_pkg::ST_FIN : plli_pkg::ST_Q_READ;
            plli_pkg::ST_Q_READ:
                state_next = plli_pkg::ST_Q_STEP;
            plli_pkg::ST_Q_STEP:
                priority if (status.q_found) state_next = plli_pkg::ST_MUL;
                else if (status.q_last) state_next = plli_pkg::ST_FIN;
                else state_next = plli_pkg::ST_Q_READ;
            plli_pkg::ST_MUL:
                state_next = status.div_skip ? plli_pkg::ST_FIN : plli_pkg::ST_DIV;
            plli_pkg::ST_DIV:
                if (status.div_last) state_next = plli_pkg::ST_FIN;
            plli_pkg::ST_FIN:
                state_next = plli_pkg::ST_OUT;
            plli_pkg::ST_OUT:
                if (!out_valid_reg) state_next = plli_pkg::ST_IDLE;
            default:
                state_next = plli_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            plli_pkg::ST_IDLE:     cmd.capture  = in_valid;
            plli_pkg::ST_DISPATCH:
                cmd.q_start = (status.req == plli_pkg::REQ_FORWARD) ||
                              (status.req == plli_pkg::REQ_REVERSE);
            plli_pkg::ST_INS_READ: cmd.ins_read = 1'b1;
            plli_pkg::ST_INS_STEP: cmd.ins_step = 1'b1;
            plli_pkg::ST_INS_DONE: cmd.ins_done = 1'b1;
            plli_pkg::ST_Q_LO:     cmd.q_lo     = 1'b1;
            plli_pkg::ST_Q_HI:     cmd.q_hi     = 1'b1;
            plli_pkg::ST_Q_READ:   cmd.q_read   = 1'b1;
            plli_pkg::ST_Q_STEP:   cmd.q_step   = 1'b1;
            plli_pkg::ST_MUL:      cmd.mul      = 1'b1;
            plli_pkg::ST_DIV:      cmd.div_step = 1'b1;
            plli_pkg::ST_FIN:      cmd.fin      = 1'b1;
            plli_pkg::ST_OUT:
                if (!out_valid_reg)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                end
            default: ;
        endcase
    end

endmodule

@@ hdl/plli_datapath.sv @@
// Datapath for the PWL interpolator: table memories, insert shifter, search, multiply, divide.
module plli_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  plli_pkg::in_item_t  in_item,
    input  plli_pkg::cmd_t      cmd,
    output plli_pkg::status_t   status,
    output plli_pkg::out_item_t out_item
);

    localparam int IW = plli_pkg::IDX_W;
    localparam int CW = plli_pkg::CNT_W;

    // Both sorted copies stored as {key, value} pairs; bank 0 by input, bank 1 by output.
    logic [63:0] mem0 [plli_pkg::TABLE_DEPTH];
    logic [63:0] mem1 [plli_pkg::TABLE_DEPTH];

    logic [CW-1:0]      count_reg;
    plli_pkg::req_t     req_reg;
    logic signed [31:0] key_reg, outv_reg;
    logic [CW-1:0]      pos0_reg, pos1_reg;
    logic               stop0_reg, stop1_reg;
    logic [63:0]        rd0_reg, rd1_reg;
    logic [IW-1:0]      qi_reg;
    logic signed [31:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic signed [31:0] res_reg;
    logic               empty_reg, full_reg;
    logic               neg_reg;
    logic [63:0]        prod_reg;
    logic [32:0]        dxk_reg;
    logic [32:0]        rem_reg;
    logic [63:0]        quo_reg;
    logic [6:0]         dcnt_reg;
    logic               have_rd_reg;

    logic        bank_sel;
    logic [IW-1:0] rd_addr0, rd_addr1;
    logic [63:0] rd_q;
    logic signed [31:0] rd_k, rd_v;
    logic signed [32:0] dy, dx, dk;
    logic [32:0]        mag;
    logic [33:0]        trial;
    logic               s0, s1;

    assign bank_sel = (req_reg == plli_pkg::REQ_REVERSE);

    // Read data is registered, so each address is issued one state ahead of its use.
    always_comb
    begin
        rd_addr0 = IW'(pos0_reg - CW'(1));
        rd_addr1 = IW'(pos1_reg - CW'(1));
        if (cmd.q_start)
        begin
            rd_addr0 = '0;
            rd_addr1 = '0;
        end
        else if (cmd.q_lo)
        begin
            rd_addr0 = IW'(count_reg - CW'(1));
            rd_addr1 = rd_addr0;
        end
        else if (cmd.q_read || cmd.q_step)
        begin
            rd_addr0 = qi_reg;
            rd_addr1 = qi_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rd0_reg <= mem0[rd_addr0];
        rd1_reg <= mem1[rd_addr1];
        if (cmd.ins_step && !stop0_reg) mem0[IW'(pos0_reg)] <= rd0_reg;
        if (cmd.ins_step && !stop1_reg) mem1[IW'(pos1_reg)] <= rd1_reg;
        if (cmd.ins_done)
        begin
            mem0[IW'(pos0_reg)] <= {key_reg, outv_reg};
            mem1[IW'(pos1_reg)] <= {outv_reg, key_reg};
        end
    end

    assign rd_q = bank_sel ? rd1_reg : rd0_reg;
    assign rd_k = rd_q[63:32];
    assign rd_v = rd_q[31:0];

    // Insertion shifts one slot per read/step pair until the key below is not greater.
    assign s0 = stop0_reg || (pos0_reg == '0) ||
                !($signed(rd0_reg[63:32]) > key_reg);
    assign s1 = stop1_reg || (pos1_reg == '0) ||
                !($signed(rd1_reg[63:32]) > outv_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.fin && req_reg == plli_pkg::REQ_CLEAR)
            count_reg <= '0;
        else if (cmd.ins_done)
            count_reg <= count_reg + CW'(1);
    end

    assign dy  = 33'(y1_reg) - 33'(y0_reg);
    assign dx  = 33'(key_reg) - 33'(x0_reg);
    assign dk  = 33'(x1_reg) - 33'(x0_reg);
    assign mag = dy[32] ? 33'(-dy) : dy;
    assign trial = {rem_reg, quo_reg[63]} - {1'b0, dxk_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg     <= plli_pkg::req_t'(in_item.req_type);
            key_reg     <= in_item.key_value;
            outv_reg    <= in_item.out_value;
            res_reg     <= '0;
            empty_reg   <= 1'b0;
            full_reg    <= 1'b0;
            pos0_reg    <= count_reg;
            pos1_reg    <= count_reg;
            stop0_reg   <= 1'b0;
            stop1_reg   <= 1'b0;
            qi_reg      <= '0;
            dcnt_reg    <= '0;
            have_rd_reg <= 1'b0;
        end
        if (cmd.ins_read)
        begin
            have_rd_reg <= 1'b1;
        end
        if (cmd.ins_step)
        begin
            stop0_reg <= s0;
            stop1_reg <= s1;
            if (!s0) pos0_reg <= pos0_reg - CW'(1);
            if (!s1) pos1_reg <= pos1_reg - CW'(1);
        end
        if (cmd.q_lo && key_reg <= rd_k)
            res_reg <= rd_v;
        if (cmd.q_hi && key_reg >= rd_k)
            res_reg <= rd_v;
        if (cmd.q_read)
        begin
            x0_reg <= rd_k;
            y0_reg <= rd_v;
        end
        if (cmd.q_step)
        begin
            x1_reg <= rd_k;
            y1_reg <= rd_v;
            qi_reg <= qi_reg + IW'(1);
            if (!status.q_found && status.q_last)
                res_reg <= rd_v;
        end
        if (cmd.mul)
        begin
            // |dy| and dx both fit in 32 bits, so the exact product fits in 64.
            neg_reg  <= dy[32];
            prod_reg <= 64'(mag[31:0]) * 64'(dx[31:0]);
            dxk_reg  <= dk;
            rem_reg  <= '0;
            dcnt_reg <= '0;
            if (x1_reg == x0_reg) res_reg <= y0_reg;
        end
        if (cmd.div_step)
        begin
            if (dcnt_reg == 7'd0)
                quo_reg <= prod_reg;
            dcnt_reg <= dcnt_reg + 7'd1;
        end
        if (cmd.div_step && dcnt_reg != 7'd0)
        begin
            if (!trial[33])
            begin
                rem_reg <= trial[32:0];
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[31:0], quo_reg[63]};
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
        if (cmd.fin)
        begin
            if ((req_reg == plli_pkg::REQ_FORWARD || req_reg == plli_pkg::REQ_REVERSE)
                && count_reg == '0)
                empty_reg <= 1'b1;
            if (req_reg == plli_pkg::REQ_LOAD && count_reg == CW'(plli_pkg::TABLE_DEPTH)
                && !have_rd_reg)
                full_reg <= 1'b1;
            // The count reaches 65 only after the load step and all 64 divide steps.
            if (dcnt_reg == 7'd65)
                res_reg <= neg_reg ? y0_reg - quo_reg[31:0] : y0_reg + quo_reg[31:0];
        end
        if (cmd.out_load)
        begin
            out_item.result_value <= res_reg;
            out_item.table_empty  <= empty_reg;
            out_item.table_full   <= full_reg;
        end
    end

    // A bracket (k[i] <= v <= k[i+1]) is tested as the upper entry arrives.
    assign status.req        = req_reg;
    assign status.count_zero = (count_reg == '0);
    assign status.count_full = (count_reg == CW'(plli_pkg::TABLE_DEPTH));
    assign status.ins_stop   = s0 && s1;
    assign status.q_below_lo = (key_reg <= rd_k);
    assign status.q_above_hi = (key_reg >= rd_k);
    assign status.q_found    = (key_reg >= x0_reg) && (key_reg <= rd_k) && (qi_reg != '0);
    assign status.q_last     = (CW'(qi_reg) + CW'(1) >= count_reg);
    assign status.div_skip   = (x1_reg == x0_reg);
    assign status.div_last   = (dcnt_reg == 7'd64);

endmodule

@@ tb/tb_top.sv @@
// Testbench for the piecewise-linear lookup table interpolator core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    plli_pkg::in_item_t  in_data;
    logic                out_valid;
    logic                out_ready;
    plli_pkg::out_item_t out_data;

    piecewise_linear_lut_interpolator_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // The clock runs at a 10 ns period.
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The testbench keeps its own copy of the breakpoint table. The stores are
    // 64-bit signed so that differences and products never wrap.
    longint by_key_keys [plli_pkg::TABLE_DEPTH];
    longint by_key_vals [plli_pkg::TABLE_DEPTH];
    longint by_val_keys [plli_pkg::TABLE_DEPTH];
    longint by_val_vals [plli_pkg::TABLE_DEPTH];
    int     table_size;

    plli_pkg::out_item_t pending_answers [$];
    int        error_count;
    int        sent_count;
    int        checked_count;
    int        query_count;
    int        full_count;
    int        empty_count;
    int        idle_cycles;

    // Returns a gap length: mostly zero or short, now and then long.
    function automatic int pick_gap();
        int roll;
        begin
            roll = $urandom_range(0, 99);
            if (roll < 40)
                pick_gap = 0;
            else if (roll < 92)
                pick_gap = $urandom_range(1, 3);
            else
                pick_gap = $urandom_range(10, 60);
        end
    endfunction

    // Inserts a pair after every existing equal key.
    task automatic insert_sorted(ref longint keys [plli_pkg::TABLE_DEPTH],
                                 ref longint vals [plli_pkg::TABLE_DEPTH],
                                 input longint k, input longint v);
        int pos;
        begin
            pos = table_size;
            while (pos > 0 && keys[pos - 1] > k)
            begin
                keys[pos] = keys[pos - 1];
                vals[pos] = vals[pos - 1];
                pos--;
            end
            keys[pos] = k;
            vals[pos] = v;
        end
    endtask

    // Linear interpolation with an exact product and a quotient truncated
    // toward zero. Equal bracketing keys give the lower output.
    function automatic longint interpolate(longint x, longint x0, longint x1,
                                           longint y0, longint y1);
        longint dy;
        logic [127:0] prod;
        logic [127:0] quot;
        begin
            if (x1 == x0)
                return y0;
            dy = y1 - y0;
            prod = 128'(dy < 0 ? -dy : dy) * 128'(x - x0);
            quot = prod / 128'(x1 - x0);
            return dy < 0 ? y0 - longint'(quot) : y0 + longint'(quot);
        end
    endfunction

    // Clamps to the end entries, lower end first, then finds the first bracket.
    function automatic longint lookup_sorted(longint keys [plli_pkg::TABLE_DEPTH],
                                             longint vals [plli_pkg::TABLE_DEPTH],
                                             longint v);
        begin
            if (v <= keys[0])
                return vals[0];
            if (v >= keys[table_size - 1])
                return vals[table_size - 1];
            for (int i = 0; i + 1 < table_size; i++)
                if (v >= keys[i] && v <= keys[i + 1])
                    return interpolate(v, keys[i], keys[i + 1], vals[i], vals[i + 1]);
            return vals[table_size - 1];
        end
    endfunction

    // Works out the answer to one request and updates the table copy.
    task automatic predict_answer(input plli_pkg::in_item_t item);
        plli_pkg::out_item_t ans;
        longint    k;
        longint    o;
        begin
            ans = '0;
            k = longint'(item.key_value);
            o = longint'(item.out_value);
            case (plli_pkg::req_t'(item.req_type))
                plli_pkg::REQ_LOAD:
                begin
                    if (table_size >= plli_pkg::TABLE_DEPTH)
                    begin
                        ans.table_full = 1'b1;
                        full_count++;
                    end
                    else
                    begin
                        insert_sorted(by_key_keys, by_key_vals, k, o);
                        insert_sorted(by_val_keys, by_val_vals, o, k);
                        table_size++;
                    end
                end
                plli_pkg::REQ_FORWARD, plli_pkg::REQ_REVERSE:
                begin
                    query_count++;
                    if (table_size == 0)
                    begin
                        ans.table_empty = 1'b1;
                        empty_count++;
                    end
                    else if (plli_pkg::req_t'(item.req_type) == plli_pkg::REQ_FORWARD)
                        ans.result_value = 32'(lookup_sorted(by_key_keys, by_key_vals, k));
                    else
                        ans.result_value = 32'(lookup_sorted(by_val_keys, by_val_vals, k));
                end
                default:
                    table_size = 0;
            endcase
            pending_answers = {pending_answers, ans};
        end
    endtask

    // Sends one request after a random gap and holds it until it is taken.
    // Valid stays high after acceptance only when the next request follows at once.
    task automatic send_request(input plli_pkg::req_t req, input logic [31:0] key,
                                input logic [31:0] val);
        int gap;
        plli_pkg::in_item_t item;
        begin
            gap = pick_gap();
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            item.req_type = req;
            item.key_value = key;
            item.out_value = val;
            in_valid <= 1'b1;
            in_data <= item;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            predict_answer(item);
            sent_count++;
        end
    endtask

    // Random 32-bit value: often small around zero, now and then the largest or smallest value, else anywhere.
    function automatic logic [31:0] pick_value();
        int roll;
        begin
            roll = $urandom_range(0, 9);
            if (roll < 4)
                pick_value = 32'($signed($urandom_range(0, 2000)) - 1000) <<< 12;
            else if (roll < 5)
                pick_value = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            else
                pick_value = $urandom;
        end
    endfunction

    // Drops valid and waits until every expected answer has been checked.
    task automatic wait_drained();
        begin
            in_valid <= 1'b0;
            while (pending_answers.size() != 0)
                @(posedge clk);
        end
    endtask

    // Queries on an empty table, the extremes, duplicate keys and a rejected
    // load into a full table.
    task automatic test_directed();
        begin
            send_request(plli_pkg::REQ_FORWARD, 32'h0, 32'h0);
            send_request(plli_pkg::REQ_REVERSE, 32'h7fffffff, 32'h0);
            send_request(plli_pkg::REQ_LOAD, 32'h80000000, 32'h7fffffff);
            send_request(plli_pkg::REQ_LOAD, 32'h7fffffff, 32'h80000000);
            send_request(plli_pkg::REQ_FORWARD, 32'h0, 32'h0);
            send_request(plli_pkg::REQ_REVERSE, 32'h00010000, 32'h0);
            send_request(plli_pkg::REQ_FORWARD, 32'h80000000, 32'h0);
            send_request(plli_pkg::REQ_FORWARD, 32'h7fffffff, 32'h0);
            send_request(plli_pkg::REQ_CLEAR, 32'hffffffff, 32'hffffffff);
            send_request(plli_pkg::REQ_REVERSE, 32'h0, 32'h0);
            send_request(plli_pkg::REQ_LOAD, 32'h00010000, 32'h00050000);
            send_request(plli_pkg::REQ_LOAD, 32'h00010000, 32'h00090000);
            send_request(plli_pkg::REQ_LOAD, 32'h00030000, 32'h00050000);
            send_request(plli_pkg::REQ_FORWARD, 32'h00010000, 32'h0);
            send_request(plli_pkg::REQ_FORWARD, 32'h00020000, 32'h0);
            send_request(plli_pkg::REQ_REVERSE, 32'h00050000, 32'h0);
            send_request(plli_pkg::REQ_REVERSE, 32'h00070000, 32'h0);
            for (int i = 0; i < 14; i++)
                send_request(plli_pkg::REQ_LOAD, pick_value(), pick_value());
            send_request(plli_pkg::REQ_FORWARD, pick_value(), 32'h0);
            send_request(plli_pkg::REQ_CLEAR, 32'h0, 32'h0);
        end
    endtask

    // Well-formed fill-then-query sequences with random content, plus noise.
    task automatic test_random(input int total);
        int fill;
        int kind;
        begin
            while (sent_count < total)
            begin
                fill = $urandom_range(0, 9) == 0 ? 18 : $urandom_range(1, 8);
                for (int i = 0; i < fill; i++)
                    send_request(plli_pkg::REQ_LOAD, pick_value(), pick_value());
                for (int i = $urandom_range(3, 12); i > 0; i--)
                begin
                    kind = $urandom_range(0, 19);
                    if (kind == 0)
                        send_request(plli_pkg::REQ_LOAD, pick_value(), pick_value());
                    else
                        send_request(kind[0] ? plli_pkg::REQ_FORWARD : plli_pkg::REQ_REVERSE,
                                     pick_value(), $urandom);
                end
                send_request(plli_pkg::REQ_CLEAR, $urandom, $urandom);
            end
        end
    endtask

    // The sender holds off until the block has answered everything.
    task automatic test_drain_pause();
        begin
            send_request(plli_pkg::REQ_LOAD, 32'h00020000, 32'hfffe0000);
            send_request(plli_pkg::REQ_FORWARD, 32'h00020000, 32'h0);
            wait_drained();
            send_request(plli_pkg::REQ_REVERSE, 32'hfffe0000, 32'h0);
            send_request(plli_pkg::REQ_CLEAR, 32'h0, 32'h0);
        end
    endtask

    // The receiver stalls at random, in bursts, with some stretches of none.
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            out_ready <= 1'b0;
            stall_left <= pick_gap();
        end
        else
            out_ready <= 1'b1;
    end

    // Checks each result transaction against the oldest expected answer.
    always @(posedge clk)
    begin
        plli_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_answers.size() == 0)
            begin
                $display("%0t: unexpected result, actual %h", $time, out_data);
                error_count++;
            end
            else
            begin
                want = pending_answers.pop_front();
                checked_count++;
                if (out_data.result_value !== want.result_value)
                begin
                    $display("%0t: result_value expected %h actual %h", $time,
                             want.result_value, out_data.result_value);
                    error_count++;
                end
                if (out_data.table_empty !== want.table_empty)
                begin
                    $display("%0t: table_empty expected %b actual %b", $time,
                             want.table_empty, out_data.table_empty);
                    error_count++;
                end
                if (out_data.table_full !== want.table_full)
                begin
                    $display("%0t: table_full expected %b actual %b", $time,
                             want.table_full, out_data.table_full);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: counts cycles with no transfer in either direction and ends the run
    // with errors once the count reaches its limit, since the block has then hung.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 5000)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        idle_cycles = 0;
        error_count = 0;
        sent_count = 0;
        checked_count = 0;
        query_count = 0;
        full_count = 0;
        empty_count = 0;
        table_size = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_drain_pause();
        test_random(800);
        wait_drained();
        repeat (120) @(posedge clk);
        if (pending_answers.size() != 0)
            error_count++;
        $display("Run covered %0d requests and %0d checked results:", sent_count, checked_count);
        $display("  %0d queries, %0d on an empty table, %0d loads rejected as full.",
                 query_count, empty_count, full_count);
        if (error_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end
endmodule

@@ filelist.f @@
hdl/plli_pkg.sv
hdl/plli_ctrl.sv
hdl/plli_datapath.sv
hdl/piecewise_linear_lut_interpolator_core.sv
tb/tb_top.sv
